[rtl/wii_pkg.sv]
// ----------------------------------------------------------------------------
// wii_pkg
// Shared widths, constants, transaction sideband type and index helpers for
// the world-space inverse inertia pipeline.
// ----------------------------------------------------------------------------
package wii_pkg;

   // unique entries of a symmetric 3x3 matrix
   localparam int NUM_SYM = 6;

   // adjugate / determinant widths (exact)
   localparam int ADJ_W = 65;
   localparam int DET_W = 97;

   // divider: |adj| magnitude, |det| magnitude, remainder, quotient
   localparam int NUM_W     = 64;
   localparam int DEN_W     = 96;
   localparam int FRAC_W    = 32;
   localparam int REM_W     = NUM_W + FRAC_W;
   localparam int QUOT_W    = 33;
   localparam int DIV_STEPS = QUOT_W;
   localparam int CMP_W     = DEN_W + QUOT_W;

   // inverse entry saturation limits (magnitudes)
   localparam logic [QUOT_W-1:0] INV_POS_LIM = 33'h0_7FFF_FFFF;
   localparam logic [QUOT_W-1:0] INV_NEG_LIM = 33'h0_8000_0000;
   localparam int INV_W = 32;

   // rotation / transform widths
   localparam int RAW_W   = 36;
   localparam int ROT_W   = 20;
   localparam int PROD1_W = ROT_W + INV_W;
   localparam int SUM1_W  = PROD1_W + 2;
   localparam int T_W     = 41;
   localparam int PROD2_W = T_W + ROT_W;
   localparam int SUM2_W  = PROD2_W + 2;
   localparam int OUT_W   = 32;

   // round-to-nearest by 2^14
   localparam int RND_SHIFT = 14;
   localparam int RND_HALF  = 8192;

   // 1.0 at scale 2^28
   localparam logic signed [RAW_W-1:0] ROT_ONE = 36'sd268435456;

   // stage counts
   localparam int ADJ_LAT   = 4;
   localparam int INV_LAT   = DIV_STEPS + 2;
   localparam int XFORM_LAT = 6;
   localparam int LATENCY   = ADJ_LAT + INV_LAT + XFORM_LAT;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   // sideband that travels with each transaction
   typedef struct packed {
      quat_type quat;
      logic     mass_pos;
      logic     det_zero;
   } meta_type;

   // packed index of symmetric entry (row, col)
   function automatic int sym_index(input int row, input int col);
      int lo;
      int hi;
      lo = (row < col) ? row : col;
      hi = (row < col) ? col : row;
      case (lo)
         0:       return hi;
         1:       return hi + 2;
         default: return 5;
      endcase
   endfunction

   function automatic int sym_row(input int idx);
      if (idx < 3) return 0;
      else if (idx < 5) return 1;
      else return 2;
   endfunction

   function automatic int sym_col(input int idx);
      if (idx < 3) return idx;
      else if (idx < 5) return idx - 2;
      else return 2;
   endfunction

endpackage

[rtl/wii_adj_det.sv]
// ----------------------------------------------------------------------------
// wii_adj_det
// Adjugate and determinant of the symmetric local tensor, four stages:
// products, adjugate, split partial products, determinant sum.
// ----------------------------------------------------------------------------
module wii_adj_det (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  wii_pkg::meta_type                      in_meta,
   input  logic signed [31:0]                     in_xx,
   input  logic signed [31:0]                     in_xy,
   input  logic signed [31:0]                     in_xz,
   input  logic signed [31:0]                     in_yy,
   input  logic signed [31:0]                     in_yz,
   input  logic signed [31:0]                     in_zz,
   output logic                                   out_valid,
   output wii_pkg::meta_type                      out_meta,
   output logic signed [wii_pkg::ADJ_W-1:0]       out_adj [wii_pkg::NUM_SYM],
   output logic signed [wii_pkg::DET_W-1:0]       out_det
);
   import wii_pkg::*;

   logic [ADJ_LAT-1:0]        valid_ff;
   meta_type                  meta1_ff, meta2_ff, meta3_ff, meta4_ff;
   logic signed [63:0]        prod_ff [2*NUM_SYM];
   logic signed [31:0]        col1_ff [3];
   logic signed [31:0]        col2_ff [3];
   logic signed [ADJ_W-1:0]   adj2_ff [NUM_SYM];
   logic signed [ADJ_W-1:0]   adj3_ff [NUM_SYM];
   logic signed [ADJ_W-1:0]   adj4_ff [NUM_SYM];
   logic signed [ADJ_W-1:0]   plo_ff [3];
   logic signed [ADJ_W-1:0]   phi_ff [3];
   logic signed [DET_W-1:0]   det_in;
   logic signed [DET_W-1:0]   det4_ff;

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ADJ_LAT-2:0], in_valid};
      end
   end

   // stage 1: cofactor products
   always_ff @(posedge clock) begin
      meta1_ff    <= in_meta;
      col1_ff[0]  <= in_xx;
      col1_ff[1]  <= in_xy;
      col1_ff[2]  <= in_xz;
      prod_ff[0]  <= in_yy * in_zz;
      prod_ff[1]  <= in_yz * in_yz;
      prod_ff[2]  <= in_xz * in_yz;
      prod_ff[3]  <= in_xy * in_zz;
      prod_ff[4]  <= in_xy * in_yz;
      prod_ff[5]  <= in_xz * in_yy;
      prod_ff[6]  <= in_xx * in_zz;
      prod_ff[7]  <= in_xz * in_xz;
      prod_ff[8]  <= in_xy * in_xz;
      prod_ff[9]  <= in_xx * in_yz;
      prod_ff[10] <= in_xx * in_yy;
      prod_ff[11] <= in_xy * in_xy;
   end

   // stage 2: adjugate entries
   always_ff @(posedge clock) begin
      meta2_ff <= meta1_ff;
      col2_ff  <= col1_ff;
      for (int i = 0; i < NUM_SYM; i++) begin
         adj2_ff[i] <= ADJ_W'(prod_ff[2*i]) - ADJ_W'(prod_ff[2*i+1]);
      end
   end

   // stage 3: first row of adjugate times first column, split in halves
   always_ff @(posedge clock) begin
      meta3_ff <= meta2_ff;
      adj3_ff  <= adj2_ff;
      for (int k = 0; k < 3; k++) begin
         plo_ff[k] <= $signed({1'b0, adj2_ff[k][31:0]}) * col2_ff[k];
         phi_ff[k] <= $signed(adj2_ff[k][ADJ_W-1:32]) * col2_ff[k];
      end
   end

   // stage 4: determinant
   always_comb begin
      det_in = '0;
      for (int k = 0; k < 3; k++) begin
         det_in = det_in + (DET_W'(phi_ff[k]) <<< 32) + DET_W'(plo_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      meta4_ff <= '{quat: meta3_ff.quat, mass_pos: meta3_ff.mass_pos,
                    det_zero: (det_in == '0)};
      adj4_ff  <= adj3_ff;
      det4_ff  <= det_in;
   end

   assign out_valid = valid_ff[ADJ_LAT-1];
   assign out_meta  = meta4_ff;
   assign out_adj   = adj4_ff;
   assign out_det   = det4_ff;

endmodule

[rtl/wii_inverse.sv]
// ----------------------------------------------------------------------------
// wii_inverse
// Six pipelined restoring dividers: inverse entry = adj * 2^32 / det, toward
// zero, saturated to Q16.16. One quotient bit per stage.
// ----------------------------------------------------------------------------
module wii_inverse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  wii_pkg::meta_type                   in_meta,
   input  logic signed [wii_pkg::ADJ_W-1:0]    in_adj [wii_pkg::NUM_SYM],
   input  logic signed [wii_pkg::DET_W-1:0]    in_det,
   output logic                                out_valid,
   output wii_pkg::meta_type                   out_meta,
   output logic signed [wii_pkg::INV_W-1:0]    out_inv [wii_pkg::NUM_SYM]
);
   import wii_pkg::*;

   logic                      valid_ff [DIV_STEPS+1];
   meta_type                  meta_ff  [DIV_STEPS+1];
   logic [DEN_W-1:0]          dabs_ff  [DIV_STEPS+1];
   logic [REM_W-1:0]          rem_ff   [DIV_STEPS+1][NUM_SYM];
   logic [QUOT_W-1:0]         quo_ff   [DIV_STEPS+1][NUM_SYM];
   logic                      neg_ff   [DIV_STEPS+1][NUM_SYM];
   logic                      ovf_ff   [1:DIV_STEPS][NUM_SYM];
   logic signed [ADJ_W-1:0]   adj_neg  [NUM_SYM];
   logic signed [DET_W-1:0]   det_neg;
   logic [QUOT_W-1:0]         q_sat    [NUM_SYM];
   logic [QUOT_W-1:0]         q_neg    [NUM_SYM];
   logic [INV_W-1:0]          inv_in   [NUM_SYM];
   logic [INV_W-1:0]          inv_ff   [NUM_SYM];
   logic                      out_valid_ff;
   meta_type                  out_meta_ff;

   // stage 0: magnitudes and result sign
   always_comb begin
      det_neg = -in_det;
      for (int l = 0; l < NUM_SYM; l++) begin
         adj_neg[l] = -in_adj[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= in_meta;
      dabs_ff[0] <= in_det[DET_W-1] ? det_neg[DEN_W-1:0] : in_det[DEN_W-1:0];
   end

   for (genvar l = 0; l < NUM_SYM; l++) begin : g_abs
      always_ff @(posedge clock) begin
         rem_ff[0][l] <= {(in_adj[l][ADJ_W-1] ? adj_neg[l][NUM_W-1:0]
                                              : in_adj[l][NUM_W-1:0]),
                          {FRAC_W{1'b0}}};
         quo_ff[0][l] <= '0;
         neg_ff[0][l] <= in_adj[l][ADJ_W-1] ^ in_det[DET_W-1];
      end
   end

   // quotient bit stages, most significant bit first
   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      localparam int BIT = DIV_STEPS - s;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         meta_ff[s] <= meta_ff[s-1];
         dabs_ff[s] <= dabs_ff[s-1];
      end

      for (genvar l = 0; l < NUM_SYM; l++) begin : g_lane
         logic [CMP_W-1:0] shifted;
         logic             fits;

         assign shifted = {{(CMP_W-DEN_W){1'b0}}, dabs_ff[s-1]} << BIT;
         assign fits    = {{(CMP_W-REM_W){1'b0}}, rem_ff[s-1][l]} >= shifted;

         always_ff @(posedge clock) begin
            rem_ff[s][l] <= fits ? (rem_ff[s-1][l] - shifted[REM_W-1:0])
                                 : rem_ff[s-1][l];
            quo_ff[s][l] <= quo_ff[s-1][l] | (QUOT_W'(fits) << BIT);
            neg_ff[s][l] <= neg_ff[s-1][l];
         end

         // quotient beyond the kept bits: flag for saturation
         if (s == 1) begin : g_ovf
            always_ff @(posedge clock) begin
               ovf_ff[s][l] <= {{(CMP_W-REM_W){1'b0}}, rem_ff[s-1][l]} >=
                               ({{(CMP_W-DEN_W){1'b0}}, dabs_ff[s-1]} << DIV_STEPS);
            end
         end else begin : g_carry
            always_ff @(posedge clock) begin
               ovf_ff[s][l] <= ovf_ff[s-1][l];
            end
         end
      end
   end

   // saturation and sign
   always_comb begin
      for (int l = 0; l < NUM_SYM; l++) begin
         if (neg_ff[DIV_STEPS][l]) begin
            q_sat[l] = (ovf_ff[DIV_STEPS][l] || quo_ff[DIV_STEPS][l] > INV_NEG_LIM)
                       ? INV_NEG_LIM : quo_ff[DIV_STEPS][l];
         end else begin
            q_sat[l] = (ovf_ff[DIV_STEPS][l] || quo_ff[DIV_STEPS][l] > INV_POS_LIM)
                       ? INV_POS_LIM : quo_ff[DIV_STEPS][l];
         end
         q_neg[l]  = -q_sat[l];
         inv_in[l] = neg_ff[DIV_STEPS][l] ? q_neg[l][INV_W-1:0] : q_sat[l][INV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      out_meta_ff <= meta_ff[DIV_STEPS];
      inv_ff      <= inv_in;
   end

   assign out_valid = out_valid_ff;
   assign out_meta  = out_meta_ff;

   always_comb begin
      for (int l = 0; l < NUM_SYM; l++) begin
         out_inv[l] = $signed(inv_ff[l]);
      end
   end

endmodule

[rtl/wii_transform.sv]
// ----------------------------------------------------------------------------
// wii_transform
// Rotation matrix from the quaternion, then R * inverse * R^T with rounding
// to Q16.16 and saturation. Six stages.
// ----------------------------------------------------------------------------
module wii_transform (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  wii_pkg::meta_type                   in_meta,
   input  logic signed [wii_pkg::INV_W-1:0]    in_inv [wii_pkg::NUM_SYM],
   output logic                                out_valid,
   output logic                                out_updated,
   output logic                                out_singular,
   output logic signed [wii_pkg::OUT_W-1:0]    out_world [wii_pkg::NUM_SYM]
);
   import wii_pkg::*;

   logic [XFORM_LAT-1:0]        valid_ff;
   meta_type                    meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta5_ff;
   logic signed [INV_W-1:0]     inv1_ff [NUM_SYM];
   logic signed [INV_W-1:0]     inv2_ff [NUM_SYM];
   logic signed [31:0]          qxx_ff, qyy_ff, qzz_ff, qxy_ff, qxz_ff, qyz_ff;
   logic signed [31:0]          qwx_ff, qwy_ff, qwz_ff;
   logic signed [RAW_W-1:0]     raw [3][3];
   logic signed [RAW_W-1:0]     raw_rnd [3][3];
   logic signed [ROT_W-1:0]     rot2_ff [3][3];
   logic signed [ROT_W-1:0]     rot3_ff [3][3];
   logic signed [ROT_W-1:0]     rot4_ff [3][3];
   logic signed [PROD1_W-1:0]   pr_ff [3][3][3];
   logic signed [SUM1_W-1:0]    sum1 [3][3];
   logic signed [SUM1_W-1:0]    sum1_rnd [3][3];
   logic signed [T_W-1:0]       t_ff [3][3];
   logic signed [PROD2_W-1:0]   wp_ff [NUM_SYM][3];
   logic signed [SUM2_W-1:0]    sum2 [NUM_SYM];
   logic signed [SUM2_W-1:0]    sum2_rnd [NUM_SYM];
   logic signed [OUT_W-1:0]     world_in [NUM_SYM];
   logic signed [OUT_W-1:0]     world_ff [NUM_SYM];
   logic                        updated_ff;
   logic                        singular_ff;

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[XFORM_LAT-2:0], in_valid};
      end
   end

   // stage 1: quaternion products
   always_ff @(posedge clock) begin
      meta1_ff <= in_meta;
      inv1_ff  <= in_inv;
      qxx_ff   <= in_meta.quat.x * in_meta.quat.x;
      qyy_ff   <= in_meta.quat.y * in_meta.quat.y;
      qzz_ff   <= in_meta.quat.z * in_meta.quat.z;
      qxy_ff   <= in_meta.quat.x * in_meta.quat.y;
      qxz_ff   <= in_meta.quat.x * in_meta.quat.z;
      qyz_ff   <= in_meta.quat.y * in_meta.quat.z;
      qwx_ff   <= in_meta.quat.w * in_meta.quat.x;
      qwy_ff   <= in_meta.quat.w * in_meta.quat.y;
      qwz_ff   <= in_meta.quat.w * in_meta.quat.z;
   end

   // stage 2: rotation matrix at 2^28, rounded to 2^14
   always_comb begin
      raw[0][0] = ROT_ONE - ((RAW_W'(qyy_ff) + RAW_W'(qzz_ff)) <<< 1);
      raw[0][1] = (RAW_W'(qxy_ff) - RAW_W'(qwz_ff)) <<< 1;
      raw[0][2] = (RAW_W'(qxz_ff) + RAW_W'(qwy_ff)) <<< 1;
      raw[1][0] = (RAW_W'(qxy_ff) + RAW_W'(qwz_ff)) <<< 1;
      raw[1][1] = ROT_ONE - ((RAW_W'(qxx_ff) + RAW_W'(qzz_ff)) <<< 1);
      raw[1][2] = (RAW_W'(qyz_ff) - RAW_W'(qwx_ff)) <<< 1;
      raw[2][0] = (RAW_W'(qxz_ff) - RAW_W'(qwy_ff)) <<< 1;
      raw[2][1] = (RAW_W'(qyz_ff) + RAW_W'(qwx_ff)) <<< 1;
      raw[2][2] = ROT_ONE - ((RAW_W'(qxx_ff) + RAW_W'(qyy_ff)) <<< 1);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            raw_rnd[r][c] = (raw[r][c] + RAW_W'(RND_HALF)) >>> RND_SHIFT;
         end
      end
   end

   always_ff @(posedge clock) begin
      meta2_ff <= meta1_ff;
      inv2_ff  <= inv1_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            rot2_ff[r][c] <= ROT_W'(raw_rnd[r][c]);
         end
      end
   end

   // stage 3: R * inverse products
   always_ff @(posedge clock) begin
      meta3_ff <= meta2_ff;
      rot3_ff  <= rot2_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               pr_ff[r][c][k] <= rot2_ff[r][k] * inv2_ff[sym_index(k, c)];
            end
         end
      end
   end

   // stage 4: T = round(R * inverse)
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sum1[r][c] = SUM1_W'(pr_ff[r][c][0]) + SUM1_W'(pr_ff[r][c][1]) +
                         SUM1_W'(pr_ff[r][c][2]);
            sum1_rnd[r][c] = (sum1[r][c] + SUM1_W'(RND_HALF)) >>> RND_SHIFT;
         end
      end
   end

   always_ff @(posedge clock) begin
      meta4_ff <= meta3_ff;
      rot4_ff  <= rot3_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            t_ff[r][c] <= T_W'(sum1_rnd[r][c]);
         end
      end
   end

   // stage 5: T * R^T products, upper triangle only
   always_ff @(posedge clock) begin
      meta5_ff <= meta4_ff;
      for (int e = 0; e < NUM_SYM; e++) begin
         for (int k = 0; k < 3; k++) begin
            wp_ff[e][k] <= t_ff[sym_row(e)][k] * rot4_ff[sym_col(e)][k];
         end
      end
   end

   // stage 6: round, saturate, zero on skip or singular tensor
   always_comb begin
      for (int e = 0; e < NUM_SYM; e++) begin
         sum2[e]     = SUM2_W'(wp_ff[e][0]) + SUM2_W'(wp_ff[e][1]) +
                       SUM2_W'(wp_ff[e][2]);
         sum2_rnd[e] = (sum2[e] + SUM2_W'(RND_HALF)) >>> RND_SHIFT;
         if (!meta5_ff.mass_pos || meta5_ff.det_zero) begin
            world_in[e] = '0;
         end else if (sum2_rnd[e] > SUM2_W'(64'sd2147483647)) begin
            world_in[e] = 32'sh7FFF_FFFF;
         end else if (sum2_rnd[e] < SUM2_W'(-64'sd2147483648)) begin
            world_in[e] = 32'sh8000_0000;
         end else begin
            world_in[e] = OUT_W'(sum2_rnd[e]);
         end
      end
   end

   always_ff @(posedge clock) begin
      world_ff    <= world_in;
      updated_ff  <= meta5_ff.mass_pos;
      singular_ff <= meta5_ff.mass_pos & meta5_ff.det_zero;
   end

   assign out_valid    = valid_ff[XFORM_LAT-1];
   assign out_updated  = updated_ff;
   assign out_singular = singular_ff;
   assign out_world    = world_ff;

endmodule

[rtl/world_inverse_inertia_core.sv]
// ----------------------------------------------------------------------------
// world_inverse_inertia_core
// World-space inverse inertia tensor of one rigid body per transaction.
// ----------------------------------------------------------------------------
// A body is taken on every clock cycle that start is high and busy is low;
// busy is high only while reset is held. Each result appears on the rsp_
// ports, marked by rsp_valid for one cycle, in request order. The pipeline
// holds four stages of adjugate and determinant, thirty-three stages of
// restoring division (one quotient bit each) plus sign and saturation,
// then six stages of rotation and the two matrix products. The receiver
// has no stall; results must be taken as they come.
// ----------------------------------------------------------------------------
module world_inverse_inertia_core #(
   parameter int TAG_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [TAG_BITS-1:0]   req_body_tag,
   input  logic signed [15:0]    req_quat_w,
   input  logic signed [15:0]    req_quat_x,
   input  logic signed [15:0]    req_quat_y,
   input  logic signed [15:0]    req_quat_z,
   input  logic signed [31:0]    req_inertia_xx,
   input  logic signed [31:0]    req_inertia_xy,
   input  logic signed [31:0]    req_inertia_xz,
   input  logic signed [31:0]    req_inertia_yy,
   input  logic signed [31:0]    req_inertia_yz,
   input  logic signed [31:0]    req_inertia_zz,
   input  logic signed [31:0]    req_body_mass,
   output logic                  rsp_valid,
   output logic [TAG_BITS-1:0]   rsp_tag_out,
   output logic                  rsp_updated,
   output logic                  rsp_singular,
   output logic signed [31:0]    rsp_world_xx,
   output logic signed [31:0]    rsp_world_xy,
   output logic signed [31:0]    rsp_world_xz,
   output logic signed [31:0]    rsp_world_yy,
   output logic signed [31:0]    rsp_world_yz,
   output logic signed [31:0]    rsp_world_zz
);
   import wii_pkg::*;

   logic                     accept;
   meta_type                 in_meta;
   logic                     adj_valid;
   meta_type                 adj_meta;
   logic signed [ADJ_W-1:0]  adj [NUM_SYM];
   logic signed [DET_W-1:0]  det;
   logic                     inv_valid;
   meta_type                 inv_meta;
   logic signed [INV_W-1:0]  inv [NUM_SYM];
   logic signed [OUT_W-1:0]  world [NUM_SYM];
   logic [TAG_BITS-1:0]      tag_ff [LATENCY];

   // request transaction
   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      in_meta.quat.w   = req_quat_w;
      in_meta.quat.x   = req_quat_x;
      in_meta.quat.y   = req_quat_y;
      in_meta.quat.z   = req_quat_z;
      in_meta.mass_pos = (req_body_mass > 32'sd0);
      in_meta.det_zero = 1'b0;
   end

   wii_adj_det u_adj_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_meta   (in_meta),
      .in_xx     (req_inertia_xx),
      .in_xy     (req_inertia_xy),
      .in_xz     (req_inertia_xz),
      .in_yy     (req_inertia_yy),
      .in_yz     (req_inertia_yz),
      .in_zz     (req_inertia_zz),
      .out_valid (adj_valid),
      .out_meta  (adj_meta),
      .out_adj   (adj),
      .out_det   (det)
   );

   wii_inverse u_inverse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (adj_valid),
      .in_meta   (adj_meta),
      .in_adj    (adj),
      .in_det    (det),
      .out_valid (inv_valid),
      .out_meta  (inv_meta),
      .out_inv   (inv)
   );

   wii_transform u_transform (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (inv_valid),
      .in_meta      (inv_meta),
      .in_inv       (inv),
      .out_valid    (rsp_valid),
      .out_updated  (rsp_updated),
      .out_singular (rsp_singular),
      .out_world    (world)
   );

   // tag rides a delay line matched to the datapath
   always_ff @(posedge clock) begin
      tag_ff[0] <= req_body_tag;
      for (int i = 1; i < LATENCY; i++) begin
         tag_ff[i] <= tag_ff[i-1];
      end
   end

   assign rsp_tag_out  = tag_ff[LATENCY-1];
   assign rsp_world_xx = world[0];
   assign rsp_world_xy = world[1];
   assign rsp_world_xz = world[2];
   assign rsp_world_yy = world[3];
   assign rsp_world_yz = world[4];
   assign rsp_world_zz = world[5];

endmodule

[rtl/wii_checker.sv]
// ----------------------------------------------------------------------------
// wii_checker
// Port-level checks for world_inverse_inertia_core: fixed latency, tag order
// and the zeroed results of skipped or singular bodies.
// ----------------------------------------------------------------------------
module wii_checker #(
   parameter int TAG_BITS = 10
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [TAG_BITS-1:0]   req_body_tag,
   input logic                  rsp_valid,
   input logic [TAG_BITS-1:0]   rsp_tag_out,
   input logic                  rsp_updated,
   input logic                  rsp_singular,
   input logic signed [31:0]    rsp_world_xx,
   input logic signed [31:0]    rsp_world_xy,
   input logic signed [31:0]    rsp_world_xz,
   input logic signed [31:0]    rsp_world_yy,
   input logic signed [31:0]    rsp_world_yz,
   input logic signed [31:0]    rsp_world_zz
);
   import wii_pkg::*;

   logic world_zero;

   assign world_zero = (rsp_world_xx == '0) && (rsp_world_xy == '0) &&
                       (rsp_world_xz == '0) && (rsp_world_yy == '0) &&
                       (rsp_world_yz == '0) && (rsp_world_zz == '0);

   // every accepted request comes out after the pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("response missing after request");

   // tag order matches request order
   a_tag: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY (rsp_tag_out == $past(req_body_tag, LATENCY)))
      else $error("response tag does not match request");

   // skipped body: no singular flag, zero tensor
   a_skip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_updated) |-> (!rsp_singular && world_zero))
      else $error("skipped body with nonzero result");

   // singular tensor: zero result
   a_singular: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_updated && world_zero))
      else $error("singular body with nonzero result");

endmodule

bind world_inverse_inertia_core wii_checker #(.TAG_BITS(TAG_BITS)) u_checker (.*);
